FILE: sv/rdcl_pkg.sv
`default_nettype none
package rdcl_pkg;

  localparam int unsigned MAX_CHUNKS = 64;
  localparam int unsigned CW_W = 7;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FIRST_CHUNK = 32'd12;
  localparam logic [31:0] POS_RIFF_END = 32'd3;
  localparam logic [31:0] POS_SIZE_END = 32'd7;
  localparam logic [31:0] POS_WAVE_END = 32'd11;
  localparam logic [32:0] HDR_LAST_OFS = 33'd7;
  localparam logic [32:0] HDR_LEN = 33'd8;
  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    PH_PREAMBLE,
    PH_WALK,
    PH_STOP
  } rdcl_phase_t;

  typedef struct packed {
    logic riff;
    logic hdr8;
    logic found;
  } rdcl_flags_t;

  typedef struct packed {
    logic [31:0] size_field;
    logic        last_byte;
    logic        first_byte;
    logic [7:0]  data_byte;
  } rdcl_item_t;

  typedef struct packed {
    logic [31:0] file_length;
    logic        changed;
    logic [31:0] corrected_field;
    logic [31:0] data_offset;
    logic        found;
    logic        playable;
  } rdcl_result_t;

  function automatic logic [31:0] le32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

FILE: sv/rdcl_in_stage.sv
`default_nettype none
module rdcl_in_stage (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [rdcl_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                   in_tuser,
  input  wire logic                   in_tlast,
  input  wire logic                   advance,
  output logic                        item_valid,
  output rdcl_pkg::rdcl_item_t        item
);
  import rdcl_pkg::*;

  logic       valid_r, valid_nxt;
  rdcl_item_t item_r, item_nxt;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
      if (in_tvalid) begin
        item_nxt.data_byte  = in_tdata[7:0];
        item_nxt.size_field = in_tdata[39:8];
        item_nxt.first_byte = in_tuser;
        item_nxt.last_byte  = in_tlast;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule
`default_nettype wire

FILE: sv/rdcl_parser.sv
`default_nettype none
module rdcl_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  rdcl_pkg::rdcl_item_t      item,
  output rdcl_pkg::rdcl_result_t    result
);
  import rdcl_pkg::*;

  logic [31:0]     pos_r, pos_nxt, pos_c, pos_s;
  logic [31:0]     off_r, off_nxt, off_c, off_s;
  logic [63:0]     shift_r, shift_nxt, shift_s;
  logic [CW_W-1:0] cw_r, cw_nxt, cw_c, cw_s, cw_inc;
  rdcl_phase_t     phase_r, phase_nxt, phase_c, phase_s;
  logic [31:0]     hsv_r, hsv_nxt, hsv_c, hsv_s;
  logic [31:0]     held_r, held_nxt, held_c;
  logic [31:0]     loc_r, loc_nxt, loc_c, loc_s;
  rdcl_flags_t     flags_r, flags_nxt, flags_c, flags_s;

  logic [31:0] low, high, sz, off8, chain_nxt;
  logic        hit, wrap, is_data, inside_hdr, inside_held;

  // restart view of the state when the transaction opens a file
  assign pos_c   = item.first_byte ? '0 : pos_r;
  assign off_c   = item.first_byte ? FIRST_CHUNK : off_r;
  assign cw_c    = item.first_byte ? '0 : cw_r;
  assign phase_c = item.first_byte ? PH_PREAMBLE : phase_r;
  assign hsv_c   = item.first_byte ? '0 : hsv_r;
  assign held_c  = item.first_byte ? item.size_field : held_r;
  assign loc_c   = item.first_byte ? '0 : loc_r;
  assign flags_c = item.first_byte ? '0 : flags_r;

  assign shift_s = {(item.first_byte ? 56'd0 : shift_r[55:0]), item.data_byte};
  assign low     = shift_s[31:0];
  assign high    = shift_s[63:32];
  assign sz      = le32(low);

  assign hit       = (phase_c == PH_WALK) && ({1'b0, pos_c} == ({1'b0, off_c} + HDR_LAST_OFS));
  assign is_data   = (high == TAG_DATA);
  assign off8      = off_c + 32'd8;
  assign chain_nxt = off8 + sz + {31'd0, sz[0]};
  assign wrap      = chain_nxt < off8;
  assign cw_inc    = cw_c + CW_W'(1);

  always_comb begin
    phase_s = phase_c;
    case (phase_c)
      PH_PREAMBLE: begin
        if (pos_c == POS_WAVE_END) begin
          phase_s = (flags_c.riff && low == TAG_WAVE) ? PH_WALK : PH_STOP;
        end
      end
      PH_WALK: begin
        if (hit && (is_data || wrap || cw_inc >= CW_W'(MAX_CHUNKS))) begin
          phase_s = PH_STOP;
        end
      end
      default: phase_s = phase_c;
    endcase
  end

  always_comb begin
    flags_s = flags_c;
    hsv_s   = hsv_c;
    off_s   = off_c;
    cw_s    = cw_c;
    loc_s   = loc_c;
    if (phase_c == PH_PREAMBLE) begin
      if (pos_c == POS_RIFF_END && low == TAG_RIFF) begin
        flags_s.riff = 1'b1;
      end
      if (pos_c == POS_SIZE_END) begin
        flags_s.hdr8 = 1'b1;
        hsv_s        = sz;
      end
    end
    if (hit) begin
      cw_s = cw_inc;
      if (is_data) begin
        flags_s.found = 1'b1;
        loc_s         = off_c;
      end else if (!wrap) begin
        off_s = chain_nxt;
      end
    end
    pos_s = (pos_c == POS_MAX) ? pos_c : pos_c + 32'd1;
  end

  assign inside_hdr  = ({1'b0, hsv_s} + HDR_LEN) < {1'b0, pos_s};
  assign inside_held = ({1'b0, held_c} + HDR_LEN) < {1'b0, pos_s};

  always_comb begin
    result.playable        = (flags_s.riff && flags_s.hdr8) ? (inside_hdr || flags_s.found)
                                                            : 1'b1;
    result.found           = flags_s.found;
    result.data_offset     = flags_s.found ? loc_s : '0;
    result.changed         = flags_s.found && !inside_held;
    result.corrected_field = result.changed ? loc_s : held_c;
    result.file_length     = pos_s;
  end

  always_comb begin
    held_nxt = held_c;
    if (item.last_byte) begin
      pos_nxt   = '0;
      off_nxt   = FIRST_CHUNK;
      shift_nxt = '0;
      cw_nxt    = '0;
      phase_nxt = PH_PREAMBLE;
      hsv_nxt   = '0;
      loc_nxt   = '0;
      flags_nxt = '0;
    end else begin
      pos_nxt   = pos_s;
      off_nxt   = off_s;
      shift_nxt = shift_s;
      cw_nxt    = cw_s;
      phase_nxt = phase_s;
      hsv_nxt   = hsv_s;
      loc_nxt   = loc_s;
      flags_nxt = flags_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      off_r   <= FIRST_CHUNK;
      shift_r <= '0;
      cw_r    <= '0;
      phase_r <= PH_PREAMBLE;
      hsv_r   <= '0;
      held_r  <= '0;
      loc_r   <= '0;
      flags_r <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      off_r   <= off_nxt;
      shift_r <= shift_nxt;
      cw_r    <= cw_nxt;
      phase_r <= phase_nxt;
      hsv_r   <= hsv_nxt;
      held_r  <= held_nxt;
      loc_r   <= loc_nxt;
      flags_r <= flags_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: sv/rdcl_out_stage.sv
`default_nettype none
module rdcl_out_stage (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  rdcl_pkg::rdcl_result_t       result,
  output logic                         free,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [rdcl_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rdcl_pkg::*;

  logic         valid_r, valid_nxt;
  rdcl_result_t data_r, data_nxt;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (free) begin
      valid_nxt = load;
    end
    if (load) begin
      data_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(rdcl_result_t))'(0), data_r};
endmodule
`default_nettype wire

FILE: sv/riff_data_chunk_locator_unit.sv
// Channel | Direction | Transaction content
// in_     | slave     | one file byte, size field, first (tuser) and last (tlast) marks
// out_    | master    | data chunk location, playability and corrected size field
//
// One byte is taken per cycle unless a last byte waits behind a stalled result, with no gaps between files.
// The last byte is registered in the input stage; its result is registered in the output stage as that byte advances.
// Cost per byte is one chunk-chain add and an offset compare in the parser.
// Synchronous active-low reset clears parse state and both valid flags.
// in_tready falls only while a last byte waits behind a stalled result.
`default_nettype none
module riff_data_chunk_locator_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [7:0] data_byte, [39:8] size_field
  input  wire logic [rdcl_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] first_byte
  input  wire logic                                in_tuser,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [0] playable, [1] found, [33:2] data_offset, [65:34] corrected_field,
  // [66] changed, [98:67] file_length, [103:99] zero
  output logic [rdcl_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import rdcl_pkg::*;

  logic         item_valid, out_free, advance;
  rdcl_item_t   item;
  rdcl_result_t result;

  assign advance = item_valid && (!item.last_byte || out_free);

  rdcl_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rdcl_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  rdcl_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && item.last_byte),
    .result     (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire

FILE: sv/rdcl_checker.sv
`default_nettype none
module rdcl_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[98:67] != 32'd0)
    else $error("zero file length");

  a_found_play: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("found file not playable");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[33:2] == 32'd0 && !out_tdata[66])
    else $error("offset or change without data chunk");
endmodule

bind riff_data_chunk_locator_unit rdcl_checker u_rdcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: bench/tb_riff_data_chunk_locator_unit.sv
`default_nettype none
module tb_riff_data_chunk_locator_unit;
  import rdcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT = 24;

  class data_chunk_tracker;
    logic [31:0]  pos;
    logic [31:0]  chunk_at;
    logic [31:0]  hdr_size;
    logic [31:0]  held;
    logic [31:0]  loc;
    logic [63:0]  recent;
    logic [6:0]   walked;
    rdcl_phase_t  phase;
    rdcl_flags_t  flags;
    rdcl_result_t pending_reports[$];
    int           errors;

    function new();
      restart();
      held = '0;
      errors = 0;
    endfunction

    function void restart();
      pos = '0;
      chunk_at = FIRST_CHUNK;
      recent = '0;
      walked = '0;
      phase = PH_PREAMBLE;
      hdr_size = '0;
      loc = '0;
      flags = '0;
    endfunction

    function logic [31:0] swap32(logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function void take_byte(logic [7:0] b, bit first, bit last, logic [31:0] sf);
      logic [31:0]  lo;
      logic [31:0]  hi;
      logic [31:0]  sz;
      logic [31:0]  hdr_end;
      logic [31:0]  nxt;
      rdcl_result_t r;
      if (first) begin
        restart();
        held = sf;
      end
      recent = {recent[55:0], b};
      lo = recent[31:0];
      hi = recent[63:32];
      case (phase)
        PH_PREAMBLE: begin
          if (pos == POS_RIFF_END && lo == TAG_RIFF) flags.riff = 1'b1;
          if (pos == POS_SIZE_END) begin
            flags.hdr8 = 1'b1;
            hdr_size = swap32(lo);
          end
          if (pos == POS_WAVE_END) phase = (flags.riff && lo == TAG_WAVE) ? PH_WALK : PH_STOP;
        end
        PH_WALK: begin
          if ({1'b0, pos} == {1'b0, chunk_at} + HDR_LAST_OFS) begin
            walked = walked + 7'd1;
            if (hi == TAG_DATA) begin
              flags.found = 1'b1;
              loc = chunk_at;
              phase = PH_STOP;
            end else begin
              sz = swap32(lo);
              hdr_end = chunk_at + HDR_LEN[31:0];
              nxt = hdr_end + sz + {31'd0, sz[0]};
              if (nxt < hdr_end) phase = PH_STOP;
              else chunk_at = nxt;
              if (walked >= MAX_CHUNKS) phase = PH_STOP;
            end
          end
        end
        default: ;
      endcase
      if (pos != POS_MAX) pos = pos + 32'd1;
      if (last) begin
        r = '0;
        if (flags.riff && flags.hdr8)
          r.playable = ({1'b0, hdr_size} + HDR_LEN < {1'b0, pos}) || flags.found;
        else
          r.playable = 1'b1;
        r.found = flags.found;
        r.data_offset = flags.found ? loc : '0;
        if (flags.found && !({1'b0, held} + HDR_LEN < {1'b0, pos})) begin
          r.corrected_field = loc;
          r.changed = 1'b1;
        end else begin
          r.corrected_field = held;
          r.changed = 1'b0;
        end
        r.file_length = pos;
        pending_reports.push_back(r);
        restart();
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [OUT_TDATA_W-1:0] word);
      rdcl_result_t want;
      rdcl_result_t got;
      if (pending_reports.size() == 0) begin
        $error("result with no file pending: %h", word);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      got = word[98:0];
      compare_field("playable", want.playable, got.playable);
      compare_field("found", want.found, got.found);
      compare_field("data_offset", want.data_offset, got.data_offset);
      compare_field("corrected_field", want.corrected_field, got.corrected_field);
      compare_field("changed", want.changed, got.changed);
      compare_field("file_length", want.file_length, got.file_length);
      compare_field("pad", '0, word[OUT_TDATA_W-1:99]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  data_chunk_tracker tracker = new();
  logic [7:0]        file_bytes[$];
  bit                steady;
  int                bytes_sent;
  int                files;
  int unsigned       cycles;

  riff_data_chunk_locator_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_report(out_tdata);
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void put_tag(logic [31:0] t);
    file_bytes.push_back(t[31:24]);
    file_bytes.push_back(t[23:16]);
    file_bytes.push_back(t[15:8]);
    file_bytes.push_back(t[7:0]);
  endfunction

  function automatic void put_le(logic [31:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[23:16]);
    file_bytes.push_back(v[31:24]);
  endfunction

  function automatic void build_wave(bit longish);
    int          n;
    int          pick;
    int          keep;
    logic [31:0] id;
    logic [31:0] sz;
    logic [31:0] len;
    logic [31:0] hdr;
    file_bytes = {};
    put_tag(TAG_RIFF);
    put_le('0);
    put_tag(TAG_WAVE);
    n = longish ? $urandom_range(61, 66) : $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      id = $urandom;
      if (id == TAG_DATA) id = ~id;
      pick = $urandom_range(11);
      if (longish) sz = $urandom_range(1);
      else if (pick == 0) sz = 32'hFFFF_FFFF;
      else if (pick == 1) sz = 32'hFFFF_FFFE - $urandom_range(15);
      else if (pick == 2) sz = $urandom;
      else sz = $urandom_range(9);
      put_tag(id);
      put_le(sz);
      if (sz < 10) repeat (sz + sz[0]) file_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(3) != 0) begin
      put_tag(TAG_DATA);
      sz = $urandom_range(6);
      put_le(sz);
      repeat (sz) file_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(4) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
    if (file_bytes.size() >= 8) begin
      len = file_bytes.size();
      case ($urandom_range(5))
        0: hdr = len - 32'd9;
        1: hdr = len - 32'd8;
        2: hdr = len - 32'd7;
        3: hdr = $urandom;
        4: hdr = '1;
        default: hdr = '0;
      endcase
      file_bytes[4] = hdr[7:0];
      file_bytes[5] = hdr[15:8];
      file_bytes[6] = hdr[23:16];
      file_bytes[7] = hdr[31:24];
    end
    if (file_bytes.size() > 11 && $urandom_range(7) == 0)
      file_bytes[$urandom_range(11)] ^= 8'h01 << $urandom_range(7);
  endfunction

  function automatic void build_noise();
    int n;
    n = $urandom_range(1, 24);
    file_bytes = {};
    if ($urandom_range(2) == 0) put_tag(TAG_RIFF);
    while (file_bytes.size() < n) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] pick_held(int len);
    case ($urandom_range(6))
      0: return len - 9;
      1: return len - 8;
      2: return $urandom;
      3: return '0;
      4: return '1;
      5: return 32'hFFFF_FFF8 - $urandom_range(3);
      default: return $urandom_range(64);
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, bit first, bit last, logic [31:0] sf);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sf, b};
    in_tuser <= first;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_byte(b, first, last, sf);
  endtask

  task automatic send_file(bit mark_first, logic [31:0] sf, bit jitter);
    bit          f;
    logic [31:0] s;
    for (int i = 0; i < file_bytes.size(); i++) begin
      f = (i == 0) ? mark_first : (jitter && $urandom_range(199) == 0);
      s = (i == 0) ? sf : $urandom;
      send_byte(file_bytes[i], f, i == file_bytes.size() - 1, s);
    end
    bytes_sent += file_bytes.size();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    in_tlast <= 1'b0;
    steady = 1'b0;
    cycles = 0;
    bytes_sent = 0;
    files = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single byte straight after reset, no start mark
    file_bytes = {8'h00};
    send_file(1'b0, '0, 1'b0);
    // shortest file that reaches a data header, size field at its maximum
    file_bytes = {};
    put_tag(TAG_RIFF);
    put_le('1);
    put_tag(TAG_WAVE);
    put_tag(TAG_DATA);
    put_le('0);
    send_file(1'b1, '1, 1'b0);
    // one-byte file with both marks
    file_bytes = {8'hFF};
    send_file(1'b1, '0, 1'b0);
    // restart after a result without a start mark, held field kept
    file_bytes = {8'h52, 8'h49};
    send_file(1'b0, 32'h1234_5678, 1'b0);

    while (bytes_sent < 1000 || files < 48) begin
      steady = (files >= 12 && files < 20);
      if (files == 4) build_wave(1'b1);
      else if ($urandom_range(9) < 7) build_wave(1'b0);
      else build_noise();
      send_file($urandom_range(9) != 0, pick_held(file_bytes.size()), 1'b1);
      files++;
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
